// ===== hw/rtl/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path unit.
// ----------------------------------------------------------------------------
package apsp_pkg;

	localparam int NodeW   = 4;
	localparam int WeightW = 16;
	localparam int DistW   = 32;
	localparam int NoPathW = 31;
	localparam int CountW  = 5;

	localparam logic [CountW-1:0]  NodeCountReset = 5'd16;
	localparam logic [NoPathW-1:0] NoPathReset    = 31'd1000000000;

	// Register selects, matched against paddr[2] (byte addresses 0 and 4).
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_NO_PATH    = 1'b1;

	typedef enum logic [1:0] {
		OP_EDGE    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [NodeW-1:0]           src;
		logic [NodeW-1:0]           dst;
		logic signed [WeightW-1:0]  weight;
		logic                       both;
		logic                       in_range;
	} cmd_t;

endpackage

// ===== hw/rtl/apsp_front.sv =====
// ----------------------------------------------------------------------------
// apsp_front
// Accepts requests, drops the ones that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module apsp_front #(
	parameter int MAX_NODES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [apsp_pkg::NodeW-1:0]  source_node,
	input  logic [apsp_pkg::NodeW-1:0]  dest_node,
	input  logic signed [apsp_pkg::WeightW-1:0] weight,
	input  logic                        both_ways,
	input  logic                        clear_busy,
	output logic                        q_valid,
	output apsp_pkg::cmd_t              q_item,
	input  logic                        q_pop
);
	import apsp_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       keep;
	logic       in_range;
	cmd_t       item;

	assign in_stall = (count_q == 2'd2) || clear_busy;
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_comb begin
		in_range = (32'(source_node) < MAX_NODES) && (32'(dest_node) < MAX_NODES);
		item.src      = source_node;
		item.dst      = dest_node;
		item.weight   = weight;
		item.both     = both_ways;
		item.in_range = in_range;
		item.op       = OP_EDGE;
		keep          = 1'b0;
		case (func)
			OP_EDGE: begin
				item.op = OP_EDGE;
				keep    = in_range;
			end
			OP_COMPUTE: begin
				item.op = OP_COMPUTE;
				keep    = 1'b1;
			end
			OP_READ: begin
				item.op = OP_READ;
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop) count_q <= count_q + 2'd1;
			else if (!push && q_pop) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= item;
	end

endmodule

// ===== hw/rtl/apsp_back.sv =====
// ----------------------------------------------------------------------------
// apsp_back
// Sequencer with the edge and distance memories; runs queued requests.
// ----------------------------------------------------------------------------
module apsp_back #(
	parameter int MAX_NODES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  apsp_pkg::cmd_t                q_item,
	output logic                          q_pop,
	output logic                          clear_busy,
	input  logic [apsp_pkg::CountW-1:0]   node_count,
	input  logic [apsp_pkg::NoPathW-1:0]  no_path,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [apsp_pkg::DistW-1:0] distance
);
	import apsp_pkg::*;

	localparam int IW    = $clog2(MAX_NODES);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = IW + 1;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_EDGE2  = 10'b0000000100,
		S_INIT   = 10'b0000001000,
		S_IDRAIN = 10'b0000010000,
		S_KROW   = 10'b0000100000,
		S_KWAIT  = 10'b0001000000,
		S_RELAX  = 10'b0010000000,
		S_DRAIN  = 10'b0100000000,
		S_RDATA  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0]  clr_q;
	logic [NW-1:0]  n_q, n_new, nm1;
	logic [IW-1:0]  i_q, j_q, k_q;
	logic           last_i, last_j, last_k;
	logic [IW-1:0]  eb_src_q, eb_dst_q;
	logic signed [WeightW-1:0] w_q;

	logic           init_vld_s1, init_diag_s1;
	logic [AW-1:0]  init_addr_s1;
	logic           relax_vld_s1;
	logic [AW-1:0]  relax_addr_s1;
	logic [IW-1:0]  relax_j_s1, relax_k_s1;
	logic signed [DistW-1:0] dik_q;
	logic           rd_zero_q;
	logic           out_valid_q;
	logic signed [DistW-1:0] distance_q;

	logic [WeightW:0] edge_mem [DEPTH];
	logic             edge_we;
	logic [AW-1:0]    edge_waddr, edge_raddr;
	logic [WeightW:0] edge_wdata, edge_rdata_q;

	logic [DistW-1:0] dist_mem [DEPTH];
	logic             dist_we;
	logic [AW-1:0]    dist_waddr, ra_addr, rb_addr;
	logic [DistW-1:0] dist_wdata, ra_q, rb_q;

	logic [DistW:0]          sum;
	logic signed [DistW-1:0] cand, relax_new, init_val;
	logic                    less;
	logic [IW-1:0]           q_src, q_dst;

	assign q_src      = IW'(q_item.src);
	assign q_dst      = IW'(q_item.dst);
	assign nm1        = n_q - NW'(1);
	assign last_i     = (i_q == nm1[IW-1:0]);
	assign last_j     = (j_q == nm1[IW-1:0]);
	assign last_k     = (k_q == nm1[IW-1:0]);
	assign n_new      = (32'(node_count) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count);
	assign clear_busy = (state_q == S_CLEAR);
	assign out_valid  = out_valid_q;
	assign distance   = distance_q;

	// Candidate path through k, saturated to the signed 32-bit range.
	always_comb begin
		sum  = {dik_q[DistW-1], dik_q} + {rb_q[DistW-1], rb_q};
		cand = sum[DistW-1:0];
		if (sum[DistW] != sum[DistW-1]) begin
			cand = sum[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
		end
		less      = cand < $signed(ra_q);
		relax_new = less ? cand : $signed(ra_q);
		if (edge_rdata_q[WeightW]) begin
			init_val = DistW'($signed(edge_rdata_q[WeightW-1:0]));
		end else if (init_diag_s1) begin
			init_val = '0;
		end else begin
			init_val = {1'b0, no_path};
		end
		dist_we    = init_vld_s1 || (relax_vld_s1 && less);
		dist_waddr = init_vld_s1 ? init_addr_s1 : relax_addr_s1;
		dist_wdata = init_vld_s1 ? init_val : cand;
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		edge_we    = 1'b0;
		edge_waddr = clr_q;
		edge_wdata = '0;
		edge_raddr = {i_q, j_q};
		ra_addr    = {i_q, j_q};
		rb_addr    = {k_q, j_q};
		case (state_q)
			S_CLEAR: begin
				edge_we = 1'b1;
				if (clr_q == {AW{1'b1}}) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						OP_EDGE: begin
							q_pop      = 1'b1;
							edge_we    = 1'b1;
							edge_waddr = {q_src, q_dst};
							edge_wdata = {1'b1, q_item.weight};
							if (q_item.both) state_d = S_EDGE2;
						end
						OP_COMPUTE: begin
							q_pop = 1'b1;
							if (n_new != '0) state_d = S_INIT;
						end
						OP_READ: begin
							if (!out_valid_q) begin
								q_pop   = 1'b1;
								ra_addr = {q_src, q_dst};
								state_d = S_RDATA;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			S_EDGE2: begin
				edge_we    = 1'b1;
				edge_waddr = {eb_dst_q, eb_src_q};
				edge_wdata = {1'b1, w_q};
				state_d    = S_IDLE;
			end
			S_INIT: begin
				if (last_i && last_j) state_d = S_IDRAIN;
			end
			S_IDRAIN: begin
				state_d = S_KROW;
			end
			S_KROW: begin
				ra_addr = {i_q, k_q};
				state_d = S_KWAIT;
			end
			S_KWAIT: begin
				state_d = S_RELAX;
			end
			S_RELAX: begin
				if (last_j) state_d = (last_i && last_k) ? S_DRAIN : S_KROW;
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			S_RDATA: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			init_vld_s1  <= 1'b0;
			relax_vld_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			init_vld_s1  <= (state_q == S_INIT);
			relax_vld_s1 <= (state_q == S_RELAX);
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == S_IDLE && q_pop && q_item.op == OP_COMPUTE) begin
				n_q <= n_new;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (state_q == S_INIT || state_q == S_RELAX) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= last_i ? '0 : i_q + IW'(1);
					if (last_i && state_q == S_RELAX) k_q <= k_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			if (state_q == S_RDATA) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_pop) begin
			eb_src_q  <= q_src;
			eb_dst_q  <= q_dst;
			w_q       <= q_item.weight;
			rd_zero_q <= !q_item.in_range;
		end
		init_addr_s1  <= {i_q, j_q};
		init_diag_s1  <= (i_q == j_q);
		relax_addr_s1 <= {i_q, j_q};
		relax_j_s1    <= j_q;
		relax_k_s1    <= k_q;
		if (state_q == S_KWAIT) begin
			dik_q <= $signed(ra_q);
		end else if (relax_vld_s1 && relax_j_s1 == relax_k_s1) begin
			// The row's own entry through k is used fresh by later columns.
			dik_q <= relax_new;
		end
		if (state_q == S_RDATA) distance_q <= rd_zero_q ? '0 : $signed(ra_q);
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
		edge_rdata_q <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
		ra_q <= dist_mem[ra_addr];
		rb_q <= dist_mem[rb_addr];
	end

endmodule

// ===== hw/rtl/all_pairs_shortest_paths_unit.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths_unit
// Floyd-Warshall engine over an edge matrix and a distance matrix.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (func, source_node, dest_node, weight,
// both_ways) and wait in a two-entry queue. An add-edge request writes its edge
// entry, then the reverse entry in S_EDGE2 when stored both ways. An idle unit
// holding no result takes a read request, reads its distance and registers it
// in S_RDATA with out_valid. A compute request fills the distance matrix for n
// active nodes, then does one min-plus update per cycle in S_RELAX, with S_KROW
// and S_KWAIT before each row. Later requests queue and then stall. After reset
// the edge memory is cleared, one entry per cycle, over 2**(2*clog2(MAX_NODES))
// entries (256 for 16 nodes) with the input stalled. A stalled result holds in
// the output register; the queue keeps taking requests until full. Registers
// are to be written over the APB port while idle; this is not enforced.
// ----------------------------------------------------------------------------
module all_pairs_shortest_paths_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [apsp_pkg::NodeW-1:0]          source_node,
	input  logic [apsp_pkg::NodeW-1:0]          dest_node,
	input  logic signed [apsp_pkg::WeightW-1:0] weight,
	input  logic                                both_ways,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [apsp_pkg::DistW-1:0]   distance,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import apsp_pkg::*;

	logic [CountW-1:0]  node_count_q;
	logic [NoPathW-1:0] no_path_q;
	logic               q_valid, q_pop, clear_busy, cfg_we;
	cmd_t               q_item;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {27'd0, node_count_q}
	                                             : {1'b0, no_path_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NodeCountReset;
			no_path_q    <= NoPathReset;
		end else if (cfg_we) begin
			if (paddr[2] == REG_NODE_COUNT) node_count_q <= pwdata[CountW-1:0];
			else no_path_q <= pwdata[NoPathW-1:0];
		end
	end

	apsp_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.source_node (source_node),
		.dest_node   (dest_node),
		.weight      (weight),
		.both_ways   (both_ways),
		.clear_busy  (clear_busy),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	apsp_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.node_count (node_count_q),
		.no_path    (no_path_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.distance   (distance)
	);

	// No request may enter during the clearing pass.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> in_stall)
		else $error("request accepted during edge memory clear");

	// The queue is only drained when it holds something.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A new result always comes from an earlier read request popped from the queue, through S_RDATA.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop && q_item.op == OP_READ, 2))
		else $error("result without a read request");

endmodule

// ===== verif/all_pairs_shortest_paths_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths_unit_test
// Self-checking bench for the Floyd-Warshall shortest path unit.
// ----------------------------------------------------------------------------
// A short table of edge, compute, read and unused requests runs first. Random
// graphs with random weights, computes and distance reads follow under
// several node count and no-path settings. Every distance returned is
// checked against the table or a shortest-path model in the bench;
// both channels idle and stall at random under the first four settings.
// ----------------------------------------------------------------------------
module all_pairs_shortest_paths_unit_test;
	import apsp_pkg::*;

	localparam int Nodes = 16;
	localparam logic [2:0] AddrNodeCount = 3'd0;
	localparam logic [2:0] AddrNoPath    = 3'd4;
	localparam logic [1:0] OpUnused      = 2'd3;
	localparam int DirectedRows = 22;

	typedef struct {
		logic [1:0]         func;
		logic [NodeW-1:0]   src;
		logic [NodeW-1:0]   dst;
		logic [WeightW-1:0] weight;
		logic               both;
		bit                 has_exp;
		logic [DistW-1:0]   exp;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic [NodeW-1:0] source_node = '0;
	logic [NodeW-1:0] dest_node = '0;
	logic signed [WeightW-1:0] weight = '0;
	logic both_ways = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DistW-1:0] distance;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	all_pairs_shortest_paths_unit u_dut (.*);

	always #1 clk = ~clk;

	// Shortest-path model state.
	logic signed [WeightW-1:0] edge_w [Nodes*Nodes];
	bit                        edge_on [Nodes*Nodes];
	logic signed [DistW-1:0]   dist_mtx [Nodes*Nodes];
	logic [CountW-1:0]         node_count_reg = NodeCountReset;
	logic [NoPathW-1:0]        no_path_reg = NoPathReset;
	int                        computed_span = 0;
	logic [DistW-1:0]          pending_dist [$];
	int                        mismatches = 0;
	int                        in_idle_pct = 0;
	int                        out_idle_pct = 0;

	function automatic logic signed [DistW-1:0] sat_sum(logic signed [DistW-1:0] a,
			logic signed [DistW-1:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(32'sh7fffffff)) return 32'sh7fffffff;
		if (s < -longint'(64'sd2147483648)) return 32'sh80000000;
		return s[DistW-1:0];
	endfunction

	function automatic void relax_all();
		int n;
		logic signed [DistW-1:0] c;
		n = (node_count_reg > Nodes) ? Nodes : node_count_reg;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				dist_mtx[i*Nodes+j] = (i == j) ? 32'sd0 : {1'b0, no_path_reg};
				if (edge_on[i*Nodes+j]) dist_mtx[i*Nodes+j] = edge_w[i*Nodes+j];
			end
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					c = sat_sum(dist_mtx[i*Nodes+k], dist_mtx[k*Nodes+j]);
					if (c < dist_mtx[i*Nodes+j]) dist_mtx[i*Nodes+j] = c;
				end
		if (n > computed_span) computed_span = n;
	endfunction

	function automatic void apply_request(request_t r);
		case (r.func)
			OP_EDGE: begin
				edge_w[r.src*Nodes+r.dst] = r.weight;
				edge_on[r.src*Nodes+r.dst] = 1'b1;
				if (r.both) begin
					edge_w[r.dst*Nodes+r.src] = r.weight;
					edge_on[r.dst*Nodes+r.src] = 1'b1;
				end
			end
			OP_COMPUTE: relax_all();
			OP_READ: pending_dist.insert(pending_dist.size(),
				r.has_exp ? r.exp : dist_mtx[r.src*Nodes+r.dst]);
			default: ;
		endcase
	endfunction

	task automatic issue_request(request_t r);
		in_valid <= 1'b1;
		func <= r.func;
		source_node <= r.src;
		dest_node <= r.dst;
		weight <= r.weight;
		both_ways <= r.both;
		do @(posedge clk); while (in_stall);
		apply_request(r);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Waits for all reads to return, then for up to three computes still
	// running or queued.
	task automatic drain();
		int n;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dist.size() != 0) @(posedge clk);
		n = (node_count_reg > Nodes) ? Nodes : node_count_reg;
		repeat (3 * (n*n + n*n*(n+2) + 3) + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AddrNodeCount) node_count_reg = data[CountW-1:0];
		else no_path_reg = data[NoPathW-1:0];
		@(posedge clk);
	endtask

	function automatic request_t random_request();
		request_t r;
		int pick;
		int span;
		span = (node_count_reg == 0) ? Nodes : ((node_count_reg > Nodes) ? Nodes : node_count_reg);
		pick = $urandom_range(99);
		r.has_exp = 1'b0;
		r.exp = '0;
		r.both = 1'($urandom_range(1));
		r.weight = ($urandom_range(3) == 0) ? WeightW'($urandom())
		                                    : WeightW'($urandom_range(40) - 10);
		if ($urandom_range(4) == 0) begin
			r.src = NodeW'($urandom());
			r.dst = NodeW'($urandom());
		end else begin
			r.src = NodeW'($urandom_range(span - 1));
			r.dst = NodeW'($urandom_range(span - 1));
		end
		if (pick < 4) r.func = OP_COMPUTE;
		else if (pick < 8) r.func = OpUnused;
		else if (pick < 45 && computed_span > 0) begin
			// Only cells inside some earlier compute hold a distance.
			r.func = OP_READ;
			r.src = NodeW'($urandom_range(computed_span - 1));
			r.dst = NodeW'($urandom_range(computed_span - 1));
		end else r.func = OP_EDGE;
		return r;
	endfunction

	always @(posedge clk) out_stall <= ($urandom_range(99) < out_idle_pct);

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_dist.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected distance %0d", distance);
			end else if (pending_dist[0] !== distance) begin
				mismatches++;
				if (mismatches <= 10)
					$display("distance mismatch: expected %0d, got %0d",
						$signed(pending_dist[0]), distance);
				void'(pending_dist.pop_front());
			end else void'(pending_dist.pop_front());
		end
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		request_t plan [DirectedRows];
		logic [CountW-1:0] counts [6];
		logic [31:0] no_paths [6];
		plan = '{
			'{OP_COMPUTE, 0, 0, 0, 0, 0, 0},
			'{OP_READ, 0, 0, 0, 0, 1, 0},
			'{OP_READ, 0, 15, 0, 0, 1, 1000000000},
			'{OP_READ, 15, 15, 0, 0, 1, 0},
			'{OP_READ, 15, 0, 0, 0, 1, 1000000000},
			'{OP_EDGE, 0, 1, 16'sh7fff, 0, 0, 0},
			'{OP_EDGE, 1, 2, 16'sh8000, 0, 0, 0},
			'{OP_EDGE, 2, 2, 16'sd7, 0, 0, 0},
			'{OP_EDGE, 15, 14, 16'shffff, 1, 0, 0},
			'{OP_EDGE, 3, 4, 16'sd9, 1, 0, 0},
			'{OP_EDGE, 3, 4, 16'sd2, 0, 0, 0},
			'{OpUnused, 15, 15, 16'sh7fff, 1, 0, 0},
			'{OP_COMPUTE, 0, 0, 0, 0, 0, 0},
			'{OP_READ, 0, 1, 0, 0, 1, 32767},
			'{OP_READ, 2, 2, 0, 0, 1, 7},
			'{OP_READ, 0, 2, 0, 0, 0, 0},
			'{OP_READ, 14, 15, 0, 0, 0, 0},
			'{OP_READ, 15, 15, 0, 0, 0, 0},
			'{OP_READ, 3, 4, 0, 0, 1, 2},
			'{OP_READ, 4, 3, 0, 0, 1, 9},
			'{OP_READ, 5, 6, 0, 0, 1, 1000000000},
			'{OP_READ, 7, 7, 0, 0, 1, 0}
		};
		counts = '{16, 1, 0, 31, 5, 3};
		no_paths = '{32'h7fffffff, 0, $urandom(), 1000000000, $urandom(), 32'h7fffffff};
		for (int i = 0; i < Nodes*Nodes; i++) begin
			edge_on[i] = 1'b0;
			edge_w[i] = '0;
			dist_mtx[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// The edge memory clears itself after reset.
		repeat (300) @(posedge clk);
		for (int i = 0; i < DirectedRows; i++) issue_request(plan[i]);
		for (int s = 0; s < 6; s++) begin
			in_idle_pct = (s < 2) ? 37 : ((s < 4) ? 82 : 0);
			out_idle_pct = (s < 2) ? 82 : ((s < 4) ? 37 : 0);
			drain();
			write_reg(AddrNodeCount, {27'd0, counts[s]});
			write_reg(AddrNoPath, no_paths[s] & 32'h7fffffff);
			for (int i = 0; i < 155; i++) issue_request(random_request());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
